/* rtl/core/sgco_pkg.sv */
// Shared types and constants for the sphere / grid cell overlap block.
// No dependencies; imported by every module of the block.
`default_nettype none

package sgco_pkg;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_LEVEL    = 2'd1,
      STATUS_BOUNDS   = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CSR_ORIGIN_X  = 3'd0,
      CSR_ORIGIN_Y  = 3'd1,
      CSR_ORIGIN_Z  = 3'd2,
      CSR_BASE_SIZE = 3'd3,
      CSR_CENTER_X  = 3'd4,
      CSR_CENTER_Y  = 3'd5,
      CSR_CENTER_Z  = 3'd6,
      CSR_RADIUS    = 3'd7
   } csr_index_type;

   localparam logic [40:0] BASE_SIZE_RESET = 41'd1000;
   localparam logic [30:0] RADIUS_RESET    = 31'd1;

   typedef struct packed {
      logic signed [31:0] cell_x;
      logic signed [31:0] cell_y;
      logic signed [31:0] cell_z;
      logic [7:0]         cell_level;
   } req_type;

   typedef struct packed {
      logic       overlaps;
      status_type status;
   } rsp_type;

   // per-axis result at the last lane stage
   typedef struct packed {
      logic        far;
      logic        ovf;
      logic [61:0] sq;
   } lane_out_type;

endpackage

`default_nettype wire

/* rtl/core/sphere_grid_cell_overlap.sv */
// Top level of the sphere / grid cell overlap block: CSRs, checks, valid chain.
// Depends on sgco_pkg and sgco_axis_lane (one lane per axis).
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | req_type (cell_x/y/z, cell_level)
//   rsp     | out       | rsp_valid/rsp_stall | rsp_type (overlaps, status)
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// One cell per cycle while the result is not stalled; nine register stages, from
// the input register through the split 64x32 multiply, the two dependent 64-bit
// adds and the square to the result register.
// Reset clears the valid chain and loads the CSR defaults.
// Each stage moves when it is empty or the stage after it moves, so bubbles
// close up and a stalled result does not block input until the pipe is full.
`default_nettype none

module sphere_grid_cell_overlap
   import sgco_pkg::*;
#(
   parameter int LOD_LEVELS       = 16,
   parameter int CELL_INDEX_LIMIT = 1048576,
   parameter int MAX_EXTENT_MM    = 2147483647
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire req_type     req_data,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      rsp_type     rsp_data,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data
);

   localparam logic [7:0]         LevelLimit = 8'(LOD_LEVELS);
   localparam logic signed [31:0] IdxHi      = 32'(CELL_INDEX_LIMIT);
   localparam logic signed [31:0] IdxLo      = -32'(CELL_INDEX_LIMIT);
   localparam logic [30:0]        MaxRad     = 31'(MAX_EXTENT_MM);

   // configuration registers
   logic [63:0] org_ff [3];
   logic [63:0] ctr_ff [3];
   logic [40:0] base_ff;
   logic [30:0] rad_ff, radc_in, radc_ff;
   logic [61:0] rsq_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         org_ff[0] <= '0;
         org_ff[1] <= '0;
         org_ff[2] <= '0;
         ctr_ff[0] <= '0;
         ctr_ff[1] <= '0;
         ctr_ff[2] <= '0;
         base_ff   <= BASE_SIZE_RESET;
         rad_ff    <= RADIUS_RESET;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_ORIGIN_X:  org_ff[0] <= csr_data;
            CSR_ORIGIN_Y:  org_ff[1] <= csr_data;
            CSR_ORIGIN_Z:  org_ff[2] <= csr_data;
            CSR_BASE_SIZE: base_ff   <= csr_data[40:0];
            CSR_CENTER_X:  ctr_ff[0] <= csr_data;
            CSR_CENTER_Y:  ctr_ff[1] <= csr_data;
            CSR_CENTER_Z:  ctr_ff[2] <= csr_data;
            CSR_RADIUS:    rad_ff    <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   // clamp the radius, then square it; both settle long before an item needs them
   assign radc_in = (rad_ff == 31'd0) ? 31'd1 : ((rad_ff > MaxRad) ? MaxRad : rad_ff);

   always_ff @(posedge clock) begin
      radc_ff <= radc_in;
      rsq_ff  <= 62'(radc_ff) * 62'(radc_ff);
   end

   // valid chain and stage enables
   logic [9:1] valid_ff, valid_in, en;

   always_comb begin
      en[9] = !valid_ff[9] || !rsp_stall;
      for (int k = 8; k >= 1; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign valid_in  = {valid_ff[8:1], req_valid};
   assign req_stall = !en[1];
   assign rsp_valid = valid_ff[9];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 1; k <= 9; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // stage 1: input register, level and bounds checks
   req_type    req1_ff;
   status_type status1;
   logic [63:0] size1;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         req1_ff <= req_data;
      end
   end

   always_comb begin
      if (req1_ff.cell_level >= LevelLimit) begin
         status1 = STATUS_LEVEL;
      end else if (req1_ff.cell_x < IdxLo || req1_ff.cell_x > IdxHi ||
                   req1_ff.cell_y < IdxLo || req1_ff.cell_y > IdxHi ||
                   req1_ff.cell_z < IdxLo || req1_ff.cell_z > IdxHi) begin
         status1 = STATUS_BOUNDS;
      end else begin
         status1 = STATUS_OK;
      end
   end

   assign size1 = 64'(base_ff) << req1_ff.cell_level;

   // early status rides along stages 2..8
   status_type status_ff [2:8];

   always_ff @(posedge clock) begin
      if (en[2]) begin
         status_ff[2] <= status1;
      end
      for (int k = 3; k <= 8; k++) begin
         if (en[k]) begin
            status_ff[k] <= status_ff[k-1];
         end
      end
   end

   logic signed [31:0] lane_idx [3];
   lane_out_type       lane_out [3];

   assign lane_idx[0] = req1_ff.cell_x;
   assign lane_idx[1] = req1_ff.cell_y;
   assign lane_idx[2] = req1_ff.cell_z;

   for (genvar a = 0; a < 3; a++) begin : g_lane
      sgco_axis_lane u_lane (
         .clock    (clock),
         .stage_en (en[8:2]),
         .idx      (lane_idx[a]),
         .size     (size1),
         .org      (org_ff[a]),
         .ctr      (ctr_ff[a]),
         .radius   (radc_ff),
         .lane_out (lane_out[a])
      );
   end

   // stage 9: sum of squares, final status, result register
   logic [63:0] sum9;
   rsp_type     rsp_in, rsp_ff;

   assign sum9 = 64'(lane_out[0].sq) + 64'(lane_out[1].sq) + 64'(lane_out[2].sq);

   always_comb begin
      rsp_in.overlaps = 1'b0;
      if (status_ff[8] != STATUS_OK) begin
         rsp_in.status = status_ff[8];
      end else if (lane_out[0].ovf || lane_out[1].ovf || lane_out[2].ovf) begin
         rsp_in.status = STATUS_OVERFLOW;
      end else begin
         rsp_in.status   = STATUS_OK;
         rsp_in.overlaps = !(lane_out[0].far || lane_out[1].far || lane_out[2].far) &&
                           (sum9 <= 64'(rsq_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (en[9]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

/* rtl/core/sgco_axis_lane.sv */
// One axis of the overlap pipeline: box bounds, overflow flags, clamp distance, square.
// Depends on sgco_pkg; stage enables come from the top level.
`default_nettype none

module sgco_axis_lane
   import sgco_pkg::*;
(
   input  wire logic               clock,
   input  wire logic [8:2]         stage_en,
   input  wire logic signed [31:0] idx,
   input  wire logic [63:0]        size,
   input  wire logic [63:0]        org,
   input  wire logic [63:0]        ctr,
   input  wire logic [30:0]        radius,
   output lane_out_type            lane_out
);

   // stage 2: magnitude and sign of the index
   logic [31:0] mag2_in, mag2_ff;
   logic        neg2_ff;
   logic [63:0] size2_ff;

   // stage 3: partial products
   logic [63:0] pplo3_in, pplo3_ff, pphi3_in, pphi3_ff;
   logic        neg3_ff;
   logic [63:0] size3_ff;

   // stage 4: signed offset
   logic [95:0] full4;
   logic [63:0] off4_in, off4_ff;
   logic        ovf4_in, ovf4_ff;
   logic [63:0] size4_ff;

   // stage 5: box minimum
   logic [63:0] lo5_in, lo5_ff;
   logic        ovf5_in, ovf5_ff;
   logic [63:0] size5_ff;

   // stage 6: box maximum
   logic [63:0] sizem1;
   logic [63:0] hi6_in, hi6_ff, lo6_ff;
   logic        ovf6_in, ovf6_ff;

   // stage 7: clamp distance
   logic [63:0] dist7;
   logic [30:0] d7_ff;
   logic        far7_in, far7_ff, ovf7_ff;

   // stage 8: square
   logic [61:0] sq8_in, sq8_ff;
   logic        far8_ff, ovf8_ff;

   assign mag2_in = idx[31] ? (32'd0 - 32'(idx)) : 32'(idx);

   assign pplo3_in = 64'(size2_ff[31:0]) * 64'(mag2_ff);
   assign pphi3_in = 64'(size2_ff[63:32]) * 64'(mag2_ff);

   assign full4   = {pphi3_ff, 32'd0} + {32'd0, pplo3_ff};
   assign off4_in = neg3_ff ? (64'd0 - full4[63:0]) : full4[63:0];
   assign ovf4_in = neg3_ff ? ((|full4[95:64]) || (full4[63] && (|full4[62:0])))
                            : (|full4[95:63]);

   assign lo5_in  = org + off4_ff;
   assign ovf5_in = ovf4_ff || ((org[63] == off4_ff[63]) && (lo5_in[63] != org[63]));

   assign sizem1  = size5_ff - 64'd1;
   assign hi6_in  = lo5_ff + sizem1;
   assign ovf6_in = ovf5_ff || ((lo5_ff[63] == sizem1[63]) && (hi6_in[63] != lo5_ff[63]));

   always_comb begin
      if ($signed(ctr) < $signed(lo6_ff)) begin
         dist7 = lo6_ff - ctr;
      end else if ($signed(hi6_ff) < $signed(ctr)) begin
         dist7 = ctr - hi6_ff;
      end else begin
         dist7 = 64'd0;
      end
   end
   assign far7_in = dist7 > {33'd0, radius};

   assign sq8_in = 62'(d7_ff) * 62'(d7_ff);

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         mag2_ff  <= mag2_in;
         neg2_ff  <= idx[31];
         size2_ff <= size;
      end
      if (stage_en[3]) begin
         pplo3_ff <= pplo3_in;
         pphi3_ff <= pphi3_in;
         neg3_ff  <= neg2_ff;
         size3_ff <= size2_ff;
      end
      if (stage_en[4]) begin
         off4_ff  <= off4_in;
         ovf4_ff  <= ovf4_in;
         size4_ff <= size3_ff;
      end
      if (stage_en[5]) begin
         lo5_ff   <= lo5_in;
         ovf5_ff  <= ovf5_in;
         size5_ff <= size4_ff;
      end
      if (stage_en[6]) begin
         lo6_ff  <= lo5_ff;
         hi6_ff  <= hi6_in;
         ovf6_ff <= ovf6_in;
      end
      if (stage_en[7]) begin
         d7_ff   <= dist7[30:0];
         far7_ff <= far7_in;
         ovf7_ff <= ovf6_ff;
      end
      if (stage_en[8]) begin
         sq8_ff  <= sq8_in;
         far8_ff <= far7_ff;
         ovf8_ff <= ovf7_ff;
      end
   end

   assign lane_out.far = far8_ff;
   assign lane_out.ovf = ovf8_ff;
   assign lane_out.sq  = sq8_ff;

endmodule

`default_nettype wire

/* rtl/core/sgco_checker.sv */
// Port-level checks for sphere_grid_cell_overlap, bound to the top level.
// Depends on sgco_pkg.
`default_nettype none

module sgco_checker
   import sgco_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire req_type     req_data,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire rsp_type     rsp_data,
   input wire logic        csr_valid,
   input wire logic        csr_ready,
   input wire logic [2:0]  csr_index,
   input wire logic [63:0] csr_data
);

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // an overlap is only reported with a clean status
   a_overlap_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.overlaps) |-> (rsp_data.status == STATUS_OK))
      else $error("overlap reported with error status");

   // input is held back only when a result is waiting
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with empty result register");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind sphere_grid_cell_overlap sgco_checker u_sgco_checker (.*);

`default_nettype wire

/* dv/tb_sphere_grid_cell_overlap.sv */
// Self-checking testbench for sphere_grid_cell_overlap: cell queries against a sphere.
// Depends on sgco_pkg and the RTL top level; predicts each status/overlap in a
// small scoreboard class, drives the req and csr channels from plain tasks and the rsp stall from an always block.
`default_nettype none

module tb_sphere_grid_cell_overlap;
   import sgco_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LOD_LEVELS       = 16;
   localparam int CELL_INDEX_LIMIT = 1048576;
   localparam longint MAX_EXTENT   = 2147483647;
   localparam logic [63:0] MIN_S64 = 64'h8000_0000_0000_0000;
   localparam int LATENCY = 9;

   class overlap_scoreboard;
      logic [63:0] origin[3];
      logic [63:0] center[3];
      logic [40:0] base_size;
      logic [30:0] radius_reg;
      rsp_type     pending[$];
      int          mismatches;

      function new();
         for (int a = 0; a < 3; a++) begin
            origin[a] = '0;
            center[a] = '0;
         end
         base_size  = BASE_SIZE_RESET;
         radius_reg = RADIUS_RESET;
         mismatches = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [63:0] v);
         case (idx)
            CSR_ORIGIN_X:  origin[0] = v;
            CSR_ORIGIN_Y:  origin[1] = v;
            CSR_ORIGIN_Z:  origin[2] = v;
            CSR_BASE_SIZE: base_size = v[40:0];
            CSR_CENTER_X:  center[0] = v;
            CSR_CENTER_Y:  center[1] = v;
            CSR_CENTER_Z:  center[2] = v;
            CSR_RADIUS:    radius_reg = v[30:0];
            default: ;
         endcase
      endfunction

      // exact cell-box test using wide signed arithmetic, overflow by range
      function rsp_type predict(req_type r);
         logic signed [31:0] cidx[3];
         logic signed [130:0] edge_len, lo, hi, ctr, gap, sq, rad;
         logic signed [130:0] smin, smax;
         rsp_type res;
         logic hit;
         cidx[0] = r.cell_x;
         cidx[1] = r.cell_y;
         cidx[2] = r.cell_z;
         smin = -(131'sd1 <<< 63);
         smax = (131'sd1 <<< 63) - 1;
         rad = radius_reg;
         if (rad < 1) rad = 1;
         if (rad > MAX_EXTENT) rad = MAX_EXTENT;
         res.overlaps = 1'b0;
         res.status = STATUS_OK;
         hit = 1'b1;
         sq = 0;
         if (r.cell_level >= LOD_LEVELS) begin
            res.status = STATUS_LEVEL;
            return res;
         end
         for (int a = 0; a < 3; a++)
            if (cidx[a] < -CELL_INDEX_LIMIT || cidx[a] > CELL_INDEX_LIMIT)
               res.status = STATUS_BOUNDS;
         if (res.status != STATUS_OK) return res;
         // size is taken as a 64-bit word, as the shift is done there
         edge_len = $unsigned(64'({23'd0, base_size} << r.cell_level));
         for (int a = 0; a < 3; a++) begin
            lo = edge_len * $signed({{99{cidx[a][31]}}, cidx[a]});
            if (lo < smin || lo > smax) begin
               res.status = STATUS_OVERFLOW;
               return res;
            end
            lo = lo + $signed({{67{origin[a][63]}}, origin[a]});
            if (lo < smin || lo > smax) begin
               res.status = STATUS_OVERFLOW;
               return res;
            end
            hi = lo + edge_len - 1;
            if (hi < smin || hi > smax) begin
               res.status = STATUS_OVERFLOW;
               return res;
            end
            if (!hit) continue;
            ctr = $signed({{67{center[a][63]}}, center[a]});
            if (ctr < lo) gap = lo - ctr;
            else if (hi < ctr) gap = ctr - hi;
            else gap = 0;
            if (gap > rad) hit = 1'b0;
            else sq = sq + gap * gap;
         end
         if (hit && sq > rad * rad) hit = 1'b0;
         res.overlaps = hit;
         return res;
      endfunction

      function void note_cell(req_type r);
         pending.push_back(predict(r));
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result overlaps=%0b status=%0d",
                        got.overlaps, got.status);
            return;
         end
         want = pending.pop_front();
         if (got.status !== want.status || got.overlaps !== want.overlaps) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: expected overlaps=%0b status=%0d, got overlaps=%0b status=%0d",
                        want.overlaps, want.status, got.overlaps, got.status);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  hold_off = 0;

   overlap_scoreboard board = new();

   sphere_grid_cell_overlap DUT (
      .clock, .reset,
      .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   always #2 clock = ~clock;

   // receiver: random stall, plus a long hold-off when requested
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall && !reset) board.check_result(rsp_data);
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic write_csr(csr_index_type idx, logic [63:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, v);
      csr_valid <= 1'b0;
   endtask

   task automatic send_cell(req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      board.note_cell(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_index();
      case ($urandom_range(5))
         0: return 32'($urandom);
         1: return 32'(CELL_INDEX_LIMIT) - 32'($urandom_range(2));
         2: return -32'(CELL_INDEX_LIMIT) + 32'($urandom_range(2));
         3: return 32'($urandom_range(CELL_INDEX_LIMIT * 2)) - 32'(CELL_INDEX_LIMIT);
         default: return 32'($urandom_range(40)) - 32'd20;
      endcase
   endfunction

   function automatic req_type random_cell();
      req_type r;
      r.cell_x = pick_index();
      r.cell_y = pick_index();
      r.cell_z = pick_index();
      r.cell_level = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(15));
      return r;
   endfunction

   function automatic logic [63:0] near_value(int kind);
      case (kind)
         0: return {$urandom, $urandom};
         1: return MIN_S64 + 64'($urandom_range(3));
         2: return ~MIN_S64 - 64'($urandom_range(3));
         default: return 64'($signed($urandom_range(200000))) - 64'd100000;
      endcase
   endfunction

   task automatic random_setting(int mode);
      write_csr(CSR_ORIGIN_X, near_value(mode == 0 ? 3 : $urandom_range(3)));
      write_csr(CSR_ORIGIN_Y, near_value(mode == 0 ? 3 : $urandom_range(3)));
      write_csr(CSR_ORIGIN_Z, near_value(3));
      write_csr(CSR_BASE_SIZE, (mode == 1) ? 64'h1FF_FFFF_FFFF :
                (mode == 2) ? 64'd0 : {$urandom, $urandom} & 64'hFFFF);
      write_csr(CSR_CENTER_X, near_value(mode == 0 ? 3 : $urandom_range(3)));
      write_csr(CSR_CENTER_Y, near_value(3));
      write_csr(CSR_CENTER_Z, near_value(3));
      write_csr(CSR_RADIUS, (mode == 1) ? 64'h7FFF_FFFF : (mode == 2) ? 64'd0 :
                64'($urandom_range(300000)));
   endtask

   initial begin
      req_type r;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: defaults, then extremes of fields and registers
      r = '0;
      send_cell(r);
      r.cell_level = 8'd16; send_cell(r);
      r.cell_level = 8'd255; r.cell_x = 32'h8000_0000; send_cell(r);
      r = '0; r.cell_x = 32'(CELL_INDEX_LIMIT + 1); send_cell(r);
      r = '0; r.cell_z = -32'(CELL_INDEX_LIMIT + 1); send_cell(r);
      r = '0; r.cell_y = 32'h7FFF_FFFF; send_cell(r);
      r = '0; r.cell_x = -32'd1; r.cell_level = 8'd15; send_cell(r);
      drain();
      write_csr(CSR_BASE_SIZE, 64'h1FF_FFFF_FFFF);
      write_csr(CSR_RADIUS, 64'hFFFF_FFFF_FFFF_FFFF);
      r = '0; r.cell_level = 8'd15; r.cell_x = 32'(CELL_INDEX_LIMIT); send_cell(r);
      r.cell_x = -32'(CELL_INDEX_LIMIT); send_cell(r);
      r = '0; r.cell_x = 32'd1; r.cell_level = 8'd3; send_cell(r);
      drain();
      write_csr(CSR_BASE_SIZE, 64'd0);
      write_csr(CSR_RADIUS, 64'd0);
      write_csr(CSR_ORIGIN_X, MIN_S64);
      r = '0; send_cell(r);
      r.cell_x = 32'd5; send_cell(r);
      drain();
      write_csr(CSR_ORIGIN_X, ~MIN_S64);
      write_csr(CSR_BASE_SIZE, 64'd1);
      r = '0; send_cell(r);
      r.cell_x = 32'd1; send_cell(r);
      r.cell_x = -32'd1; send_cell(r);
      drain();
      write_csr(CSR_ORIGIN_X, 64'd0);
      write_csr(CSR_BASE_SIZE, 64'd10);
      write_csr(CSR_RADIUS, 64'd5);
      write_csr(CSR_CENTER_X, 64'd13);
      write_csr(CSR_CENTER_Y, 64'd13);
      write_csr(CSR_CENTER_Z, 64'd13);
      r = '0; r.cell_x = 32'd1; r.cell_y = 32'd1; r.cell_z = 32'd1; send_cell(r);
      r.cell_x = 32'd2; send_cell(r);
      r.cell_y = 32'd2; r.cell_z = 32'd2; send_cell(r);
      drain();

      // random phases under different idling and register settings
      for (int ph = 0; ph < 6; ph++) begin
         random_setting(ph % 4);
         send_idle_pct  = (ph % 4 == 1 || ph % 4 == 3) ? 67 : 0;
         recv_stall_pct = (ph % 4 == 2) ? 67 : (ph % 4 == 3) ? 12 : 0;
         if (ph % 4 == 3) send_idle_pct = 12;
         if (ph == 4) hold_off <= 60;
         for (int i = 0; i < 100; i++) send_cell(random_cell());
         drain();
      end
      if (board.mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #2ms;
      $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
